[design/mwv_pkg.sv]
// shared types, constants and calibration tables for the mwv sentence parser
`default_nettype none

package mwv_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SPD_W  = 14;
    localparam int unsigned ANG_W  = 9;
    localparam int unsigned LAMP_W = 2;

    localparam logic [SPD_W-1:0] ACC_MAX = 14'd9999;
    localparam logic [SPD_W-1:0] SPD_RST = 14'd100;
    localparam logic [ANG_W-1:0] ANG_RST = 9'd75;
    localparam logic [SPD_W-1:0] SPD_KNEE = 14'd900;

    // unit conversion to knots: x * 1000 / 1852 and x * 3600 / 1852 by reciprocal
    localparam int unsigned CONV_SH = 23;
    localparam logic [63:0] KPH_MUL_64 = ((64'd1 << CONV_SH) * 64'd1000 + 64'd1851) / 64'd1852;
    localparam logic [63:0] MPS_MUL_64 = ((64'd1 << CONV_SH) * 64'd3600 + 64'd1851) / 64'd1852;
    localparam logic [23:0] KPH_MUL = KPH_MUL_64[23:0];
    localparam logic [23:0] MPS_MUL = MPS_MUL_64[23:0];

    // reciprocal constants for division by 100 (shift 19), 360 (shift 22), 10 (shift 11)
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam logic [13:0] DIV360_MUL = 14'd11651;
    localparam logic [7:0]  DIV10_MUL  = 8'd205;

    localparam logic [LAMP_W-1:0] LAMP_NONE = 2'd0;
    localparam logic [LAMP_W-1:0] LAMP_ON   = 2'd1;
    localparam logic [LAMP_W-1:0] LAMP_OFF  = 2'd2;

    typedef enum logic [4:0] {
        PS_IDLE      = 5'd0,
        PS_DOLLAR    = 5'd1,
        PS_TALK1     = 5'd2,
        PS_TALK2     = 5'd3,
        PS_LEAD_M    = 5'd4,
        PS_LEAD_W    = 5'd5,
        PS_LEAD_V    = 5'd6,
        PS_LEAD_CM   = 5'd7,
        PS_ANG_INT   = 5'd9,
        PS_ANG_FRAC  = 5'd10,
        PS_ANG_REF   = 5'd11,
        PS_SPD_INT   = 5'd12,
        PS_SPD_FRAC1 = 5'd13,
        PS_SPD_FRAC  = 5'd14,
        PS_SPD_UNIT  = 5'd15,
        PS_STATUS    = 5'd16,
        PS_TRAILER   = 5'd17
    } t_pstate;

    typedef struct packed {
        logic              upd;
        logic [LAMP_W-1:0] lamp;
    } t_flags;

    typedef struct packed {
        t_flags           flg;
        logic [SPD_W-1:0] spd;
        logic [SPD_W-1:0] ang;
    } t_commit;

    // speed correction per 10 knots, in tenths of a knot
    function automatic logic signed [8:0] spd_tab(input logic [6:0] idx);
        logic signed [8:0] v;
        case (idx)
            7'd0:    v = -9'sd1;
            7'd1:    v = -9'sd11;
            7'd2:    v = -9'sd16;
            7'd3:    v = -9'sd15;
            7'd4:    v = -9'sd7;
            7'd5:    v = 9'sd7;
            7'd6:    v = 9'sd33;
            7'd7:    v = 9'sd71;
            7'd8:    v = 9'sd117;
            7'd9:    v = 9'sd177;
            default: v = 9'sd0;
        endcase
        return v;
    endfunction

    // angle deviation per 10 degrees
    function automatic logic signed [4:0] ang_tab(input logic [5:0] idx);
        logic signed [4:0] v;
        case (idx)
            6'd0:    v = 5'sd4;
            6'd1:    v = 5'sd3;
            6'd2:    v = 5'sd1;
            6'd3:    v = 5'sd0;
            6'd4:    v = -5'sd1;
            6'd5:    v = -5'sd2;
            6'd6:    v = -5'sd3;
            6'd7:    v = -5'sd6;
            6'd8:    v = -5'sd7;
            6'd9:    v = -5'sd9;
            6'd10:   v = -5'sd8;
            6'd11:   v = -5'sd8;
            6'd12:   v = -5'sd9;
            6'd13:   v = -5'sd9;
            6'd14:   v = -5'sd7;
            6'd15:   v = -5'sd7;
            6'd16:   v = -5'sd7;
            6'd17:   v = -5'sd7;
            6'd18:   v = -5'sd7;
            6'd19:   v = -5'sd5;
            6'd20:   v = -5'sd4;
            6'd21:   v = -5'sd4;
            6'd22:   v = -5'sd2;
            6'd23:   v = 5'sd0;
            6'd24:   v = 5'sd2;
            6'd25:   v = 5'sd2;
            6'd26:   v = 5'sd3;
            6'd27:   v = 5'sd5;
            6'd28:   v = 5'sd5;
            6'd29:   v = 5'sd5;
            6'd30:   v = 5'sd5;
            6'd31:   v = 5'sd6;
            6'd32:   v = 5'sd5;
            6'd33:   v = 5'sd5;
            6'd34:   v = 5'sd4;
            6'd35:   v = 5'sd4;
            default: v = 5'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/mwv_in_if.sv]
// byte input channel interface
`default_nettype none

interface mwv_in_if import mwv_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[design/mwv_out_if.sv]
// wind result channel interface
`default_nettype none

interface mwv_out_if import mwv_pkg::*;;
    logic              valid;
    logic              ready;
    logic              update;
    logic [SPD_W-1:0]  wind_speed;
    logic [ANG_W-1:0]  wind_angle;
    logic [LAMP_W-1:0] lamp_event;

    modport source(output valid, output update, output wind_speed, output wind_angle,
                   output lamp_event, input ready);
    modport sink(input valid, input update, input wind_speed, input wind_angle,
                 input lamp_event, output ready);
endinterface

`default_nettype wire

[design/mwv_parse.sv]
// sentence parser state machine with digit accumulators and unit conversion
`default_nettype none

module mwv_parse import mwv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output t_commit           o_commit
);

    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_K      = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_V      = 8'h56;
    localparam logic [BYTE_W-1:0] CH_W      = 8'h57;

    t_pstate          r_state, n_state;
    logic [SPD_W-1:0] r_ang_acc, n_ang_acc;
    logic [SPD_W-1:0] r_spd_acc, n_spd_acc;
    t_commit          r_commit, n_commit;

    logic              digit;
    logic [3:0]        dval;
    logic [37:0]       kph_prod, mps_prod;
    logic [SPD_W-1:0]  kph_val, mps_val;
    logic [SPD_W:0]    mps_raw;
    logic              quiet;
    logic              upd;
    logic [LAMP_W-1:0] lamp;

    function automatic logic [SPD_W-1:0] acc_digit(input logic [SPD_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [16:0] v;
        v = {3'b000, acc} * 17'd10 + {13'd0, d};
        return (v > {3'b000, ACC_MAX}) ? ACC_MAX : v[SPD_W-1:0];
    endfunction

    assign digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign dval  = digit ? i_byte[3:0] : 4'd0;

    assign kph_prod = {24'd0, r_spd_acc} * {14'd0, KPH_MUL};
    assign mps_prod = {24'd0, r_spd_acc} * {14'd0, MPS_MUL};
    assign kph_val  = kph_prod[CONV_SH+SPD_W-1:CONV_SH];
    assign mps_raw  = mps_prod[CONV_SH+SPD_W:CONV_SH];
    assign mps_val  = (mps_raw > {1'b0, ACC_MAX}) ? ACC_MAX : mps_raw[SPD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= PS_IDLE;
            r_ang_acc <= '0;
            r_spd_acc <= '0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_ang_acc <= n_ang_acc;
            r_spd_acc <= n_spd_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_commit <= n_commit;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ang_acc = r_ang_acc;
        n_spd_acc = r_spd_acc;
        quiet     = 1'b0;
        upd       = 1'b0;
        lamp      = LAMP_NONE;
        case (r_state)
            PS_IDLE: begin
                if (i_byte == CH_LF) begin
                    n_state = PS_DOLLAR;
                    lamp    = LAMP_ON;
                end
            end
            PS_DOLLAR:  n_state = (i_byte == CH_DOLLAR) ? PS_TALK1 : PS_IDLE;
            PS_TALK1:   n_state = PS_TALK2;
            PS_TALK2:   n_state = PS_LEAD_M;
            PS_LEAD_M:  n_state = (i_byte == CH_M) ? PS_LEAD_W : PS_IDLE;
            PS_LEAD_W:  n_state = (i_byte == CH_W) ? PS_LEAD_V : PS_IDLE;
            PS_LEAD_V:  n_state = (i_byte == CH_V) ? PS_LEAD_CM : PS_IDLE;
            PS_LEAD_CM: begin
                if (i_byte == CH_COMMA) begin
                    n_state   = PS_ANG_INT;
                    n_ang_acc = '0;
                    n_spd_acc = '0;
                end else begin
                    n_state = PS_IDLE;
                end
            end
            PS_ANG_INT: begin
                if (digit) begin
                    n_ang_acc = acc_digit(r_ang_acc, dval);
                end else if (i_byte == CH_DOT) begin
                    n_state = PS_ANG_FRAC;
                end else if (i_byte == CH_COMMA) begin
                    n_state = PS_ANG_REF;
                end
            end
            PS_ANG_FRAC: begin
                if (i_byte == CH_COMMA) begin
                    n_state = PS_ANG_REF;
                end else if (!digit) begin
                    n_state = PS_IDLE;
                end
            end
            PS_ANG_REF: begin
                if (i_byte == CH_COMMA) begin
                    n_state = PS_SPD_INT;
                end else if (i_byte != CH_R) begin
                    n_state = PS_IDLE;
                end
            end
            PS_SPD_INT: begin
                if (digit) begin
                    n_spd_acc = acc_digit(r_spd_acc, dval);
                end else if (i_byte == CH_DOT) begin
                    n_state = PS_SPD_FRAC1;
                end else if (i_byte == CH_COMMA) begin
                    n_state = PS_SPD_UNIT;
                end else begin
                    n_state = PS_IDLE;
                end
            end
            PS_SPD_FRAC1: begin
                if (digit) begin
                    n_spd_acc = acc_digit(r_spd_acc, dval);
                    n_state   = PS_SPD_FRAC;
                end else begin
                    n_state = PS_IDLE;
                end
            end
            PS_SPD_FRAC: begin
                if (i_byte == CH_COMMA) begin
                    n_state = PS_SPD_UNIT;
                end else if (!digit) begin
                    n_state = PS_IDLE;
                end
            end
            PS_SPD_UNIT: begin
                if (i_byte == CH_COMMA) begin
                    n_state = PS_STATUS;
                end else if (i_byte == CH_K) begin
                    n_spd_acc = kph_val;
                end else if (i_byte == CH_M) begin
                    n_spd_acc = mps_val;
                end else if (i_byte != CH_N) begin
                    n_state = PS_IDLE;
                end
            end
            PS_STATUS: begin
                if (i_byte == CH_A) begin
                    upd     = 1'b1;
                    n_state = PS_TRAILER;
                end else begin
                    n_state = PS_IDLE;
                end
            end
            PS_TRAILER: begin
                if (i_byte == CH_CR) begin
                    n_state = PS_IDLE;
                    quiet   = 1'b1;
                end else if (!digit && (i_byte != CH_STAR)) begin
                    n_state = PS_IDLE;
                end
            end
            default: n_state = PS_IDLE;
        endcase
        if ((n_state == PS_IDLE) && !quiet) begin
            lamp = LAMP_OFF;
        end
        n_commit.flg.upd  = upd;
        n_commit.flg.lamp = lamp;
        n_commit.spd      = r_spd_acc;
        n_commit.ang      = r_ang_acc;
    end

    assign o_commit = r_commit;

endmodule

`default_nettype wire

[design/mwv_spd_cal.sv]
// piecewise-linear speed correction, four register stages
`default_nettype none

module mwv_spd_cal import mwv_pkg::*; (
    input  logic             i_clk,
    input  logic [3:0]       i_en,
    input  logic [SPD_W-1:0] i_raw,
    output logic [SPD_W-1:0] o_spd
);

    // stage 2: segment index
    logic [SPD_W-1:0] r_v2;
    logic [6:0]       r_q2;
    logic [26:0]      q_prod;

    // stage 3: remainder and table slope
    logic [SPD_W-1:0]  r_v3;
    logic              r_big3;
    logic [6:0]        r_rem3;
    logic signed [8:0] r_lo3;
    logic signed [9:0] r_diff3;
    logic [SPD_W-1:0]  rem_full;
    logic signed [8:0] lo, hi;

    // stage 4: slope times remainder
    logic [SPD_W-1:0]   r_v4;
    logic               r_big4;
    logic signed [8:0]  r_lo4;
    logic signed [17:0] r_prod4;

    // stage 5: truncated division by 100
    logic [SPD_W-1:0]  r_v5;
    logic              r_big5;
    logic signed [8:0] r_lo5;
    logic              r_neg5;
    logic [6:0]        r_mq5;
    logic [17:0]       mag;
    logic [25:0]       mq_prod;

    logic signed [15:0] corr, sum;

    assign q_prod = {13'd0, i_raw} * {14'd0, DIV100_MUL};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_v2 <= i_raw;
            r_q2 <= q_prod[25:19];
        end
    end

    assign rem_full = r_v2 - ({7'd0, r_q2} * 14'd100);
    assign lo       = spd_tab(r_q2);
    assign hi       = spd_tab(r_q2 + 7'd1);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_v3    <= r_v2;
            r_big3  <= r_v2 > SPD_KNEE;
            r_rem3  <= rem_full[6:0];
            r_lo3   <= lo;
            r_diff3 <= $signed({hi[8], hi}) - $signed({lo[8], lo});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_v4    <= r_v3;
            r_big4  <= r_big3;
            r_lo4   <= r_lo3;
            r_prod4 <= r_diff3 * $signed({1'b0, r_rem3});
        end
    end

    assign mag     = r_prod4[17] ? (18'd0 - r_prod4) : r_prod4;
    assign mq_prod = {13'd0, mag[12:0]} * {13'd0, DIV100_MUL};

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_v5   <= r_v4;
            r_big5 <= r_big4;
            r_lo5  <= r_lo4;
            r_neg5 <= r_prod4[17];
            r_mq5  <= mq_prod[25:19];
        end
    end

    assign corr = r_neg5 ? -$signed({9'd0, r_mq5}) : $signed({9'd0, r_mq5});
    assign sum  = $signed({2'b00, r_v5}) + $signed({{7{r_lo5[8]}}, r_lo5}) + corr;

    always_comb begin
        if (r_big5) begin
            o_spd = r_v5 + 14'(spd_tab(7'd9));
        end else if (sum < 0) begin
            o_spd = '0;
        end else begin
            o_spd = sum[SPD_W-1:0];
        end
    end

endmodule

`default_nettype wire

[design/mwv_ang_cal.sv]
// angle reduction and piecewise-linear deviation correction, four register stages
`default_nettype none

module mwv_ang_cal import mwv_pkg::*; (
    input  logic             i_clk,
    input  logic [3:0]       i_en,
    input  logic [SPD_W-1:0] i_raw,
    output logic [ANG_W-1:0] o_ang
);

    // stage 2: turns count
    logic [SPD_W-1:0] r_v2;
    logic [4:0]       r_q2;
    logic [27:0]      q_prod;

    // stage 3: angle within one circle
    logic [ANG_W-1:0] r_a3;
    logic [SPD_W-1:0] a_full;

    // stage 4: segment, remainder, slope
    logic [ANG_W-1:0]  r_a4;
    logic [3:0]        r_rem4;
    logic signed [4:0] r_lo4;
    logic signed [5:0] r_diff4;
    logic [16:0]       s_prod;
    logic [5:0]        seg, seg_nx;
    logic [ANG_W-1:0]  rem_full;
    logic signed [4:0] lo, hi;

    // stage 5: slope times remainder
    logic [ANG_W-1:0]   r_a5;
    logic signed [4:0]  r_lo5;
    logic signed [10:0] r_prod5;

    logic [10:0]        mag;
    logic [17:0]        t_prod;
    logic [6:0]         tq;
    logic signed [11:0] corr, sum;

    assign q_prod = {14'd0, i_raw} * {14'd0, DIV360_MUL};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_v2 <= i_raw;
            r_q2 <= q_prod[26:22];
        end
    end

    assign a_full = r_v2 - ({9'd0, r_q2} * 14'd360);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_a3 <= a_full[ANG_W-1:0];
        end
    end

    assign s_prod   = {8'd0, r_a3} * {9'd0, DIV10_MUL};
    assign seg      = s_prod[16:11];
    assign seg_nx   = (seg == 6'd35) ? 6'd0 : seg + 6'd1;
    assign rem_full = r_a3 - ({3'd0, seg} * 9'd10);
    assign lo       = ang_tab(seg);
    assign hi       = ang_tab(seg_nx);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_a4    <= r_a3;
            r_rem4  <= rem_full[3:0];
            r_lo4   <= lo;
            r_diff4 <= $signed({hi[4], hi}) - $signed({lo[4], lo});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_a5    <= r_a4;
            r_lo5   <= r_lo4;
            r_prod5 <= r_diff4 * $signed({1'b0, r_rem4});
        end
    end

    assign mag    = r_prod5[10] ? (11'd0 - r_prod5) : r_prod5;
    assign t_prod = {8'd0, mag[9:0]} * {10'd0, DIV10_MUL};
    assign tq     = t_prod[17:11];
    assign corr   = r_prod5[10] ? -$signed({5'd0, tq}) : $signed({5'd0, tq});
    assign sum    = $signed({3'b000, r_a5}) + $signed({{7{r_lo5[4]}}, r_lo5}) + corr;
    assign o_ang  = (sum < 0) ? '0 : sum[ANG_W-1:0];

endmodule

`default_nettype wire

[design/nmea_wind_sentence_parser.sv]
// top level: mwv wind sentence parser with speed and angle calibration
//
//  channel  | direction | payload                                      | transaction
//  i_rx     | in        | rx_byte[7:0]                                 | valid & ready
//  o_wind   | out       | update, wind_speed[13:0], wind_angle[8:0],   | valid & ready
//           |           | lamp_event[1:0]                              |
//
// one byte per cycle unless an output stall backs up to the input; bytes enter a byte register
// parser state, accumulators registered; unit conversion multiplier is combinational
// calibration runs in four register stages behind the parser, then the output register
// reset clears stage valids and parser state; held speed 100, held angle 75
// an output stall backs up stage by stage; empty stages still fill while stalled
`default_nettype none

module nmea_wind_sentence_parser import mwv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mwv_in_if.sink       i_rx,
    mwv_out_if.source    o_wind
);

    localparam int unsigned STAGES = 7;

    logic [STAGES-1:0] r_vld;
    logic [STAGES:0]   adv;

    logic [BYTE_W-1:0] r_byte;
    t_commit           commit;
    t_flags            r_flg [2:5];
    logic [SPD_W-1:0]  spd_cal;
    logic [ANG_W-1:0]  ang_cal;

    t_flags            r_out_flg;
    logic [SPD_W-1:0]  r_spd_out;
    logic [ANG_W-1:0]  r_ang_out;

    assign adv[STAGES] = o_wind.ready;

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_adv
            assign adv[g] = !r_vld[g] || adv[g+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_rx.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    mwv_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_vld[0] && adv[1]),
        .i_byte   (r_byte),
        .o_commit (commit)
    );

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_flg[2] <= commit.flg;
        end
        for (int k = 3; k <= 5; k++) begin
            if (adv[k]) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    mwv_spd_cal u_spd_cal (
        .i_clk (i_clk),
        .i_en  (adv[5:2]),
        .i_raw (commit.spd),
        .o_spd (spd_cal)
    );

    mwv_ang_cal u_ang_cal (
        .i_clk (i_clk),
        .i_en  (adv[5:2]),
        .i_raw (commit.ang),
        .o_ang (ang_cal)
    );

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_out_flg <= r_flg[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_out <= SPD_RST;
            r_ang_out <= ANG_RST;
        end else if (adv[6] && r_vld[5] && r_flg[5].upd) begin
            r_spd_out <= spd_cal;
            r_ang_out <= ang_cal;
        end
    end

    assign i_rx.ready        = adv[0];
    assign o_wind.valid      = r_vld[STAGES-1];
    assign o_wind.update     = r_out_flg.upd;
    assign o_wind.lamp_event = r_out_flg.lamp;
    assign o_wind.wind_speed = r_spd_out;
    assign o_wind.wind_angle = r_ang_out;

endmodule

`default_nettype wire

[design/mwv_chk.sv]
// port-level assertion checker for the mwv sentence parser, with bind
`default_nettype none

module mwv_chk import mwv_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_update,
    input logic [SPD_W-1:0]  i_wind_speed,
    input logic [ANG_W-1:0]  i_wind_angle,
    input logic [LAMP_W-1:0] i_lamp_event
);

    logic       in_acc;
    logic       out_acc;
    logic [3:0] r_inflight;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // transactions taken and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + {3'b000, in_acc} - {3'b000, out_acc};
        end
    end

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_update) &&
            $stable(i_wind_speed) && $stable(i_wind_angle) && $stable(i_lamp_event))
        else $error("stalled result changed");

    // a commit never coincides with a lamp event
    a_upd_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_update |-> i_lamp_event == LAMP_NONE)
        else $error("lamp event on commit");

    // held readings change only with a committing result
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !($stable(i_wind_speed) && $stable(i_wind_angle))
            |-> i_out_valid && i_update)
        else $error("held reading changed without commit");

    // empty output side never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // every result has a taken input behind it, and the pipeline holds at most seven
    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight <= 4'd7) && (!i_out_valid || (r_inflight != 4'd0)))
        else $error("result without input transaction");

endmodule

bind nmea_wind_sentence_parser mwv_chk u_mwv_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_rx.valid),
    .i_in_ready   (i_rx.ready),
    .i_out_valid  (o_wind.valid),
    .i_out_ready  (o_wind.ready),
    .i_update     (o_wind.update),
    .i_wind_speed (o_wind.wind_speed),
    .i_wind_angle (o_wind.wind_angle),
    .i_lamp_event (o_wind.lamp_event)
);

`default_nettype wire
